@@ src/cursor_doubly_linked_list_macros.svh @@
// assertion macros for the cursor doubly linked list
// no dependencies
`ifndef CURSOR_DOUBLY_LINKED_LIST_MACROS_SVH
`define CURSOR_DOUBLY_LINKED_LIST_MACROS_SVH
`ifndef SYNTH
`define CDLL_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CDLL_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CDLL_ASSERT_IMPL(label, clk, rst_n, a, c)
`define CDLL_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ src/cdll_pkg.sv @@
// shared types and codes for the cursor doubly linked list
// no dependencies
package cdll_pkg;

    typedef enum logic [3:0] {
        FN_FIRST      = 4'd0,
        FN_NEXT       = 4'd1,
        FN_LAST       = 4'd2,
        FN_PREV       = 4'd3,
        FN_PUSH_FRONT = 4'd4,
        FN_PUSH_BACK  = 4'd5,
        FN_PUSH_AFTER = 4'd6,
        FN_POP_FRONT  = 4'd7,
        FN_POP_BACK   = 4'd8,
        FN_POP_CURSOR = 4'd9,
        FN_CLEAR      = 4'd10
    } func_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_FIX1,
        S_FIX2,
        S_CLEAR,
        S_DONE,
        S_INIT
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic exec;
        logic fix1;
        logic fix2;
        logic clr_step;
        logic clr_start;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic clr_last;
        logic need_fix2;
    } stat_t;

endpackage

@@ src/cdll_ctrl.sv @@
// controller state machine for the cursor doubly linked list
// depends on cdll_pkg
module cdll_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            is_clear,
    input  cdll_pkg::stat_t stat,
    output cdll_pkg::ctrl_t ctrl,
    output logic            busy
);
    import cdll_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = is_clear ? S_CLEAR : S_RD;
            S_RD:    state_next = S_EXEC;
            S_EXEC:  state_next = S_FIX1;
            S_FIX1:  state_next = stat.need_fix2 ? S_FIX2 : S_DONE;
            S_FIX2:  state_next = S_DONE;
            S_CLEAR: if (stat.clr_last) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            S_INIT:  if (stat.clr_last) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.load = (state_reg == S_IDLE) && start;
        ctrl.clr_start = ctrl.load && is_clear;
        ctrl.read = (state_reg == S_RD);
        ctrl.exec = (state_reg == S_EXEC);
        ctrl.fix1 = (state_reg == S_FIX1);
        ctrl.fix2 = (state_reg == S_FIX2);
        ctrl.clr_step = (state_reg == S_CLEAR) || (state_reg == S_INIT);
        ctrl.finish = (state_reg == S_DONE);
        busy = (state_reg != S_IDLE);
    end

endmodule

@@ src/cdll_dp.sv @@
// datapath for the cursor doubly linked list: node memories and pointers
// depends on cdll_pkg
module cdll_dp #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdll_pkg::ctrl_t       ctrl,
    input  logic [3:0]            func,
    input  logic [DATA_WIDTH-1:0] data_in,
    output cdll_pkg::stat_t       stat,
    output logic [DATA_WIDTH-1:0] data_out,
    output logic [1:0]            status,
    output logic                  done
);
    import cdll_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [PW-1:0] NONE = PW'(CAPACITY);

    logic [DATA_WIDTH-1:0] mem_data [CAPACITY];
    logic [PW-1:0]         mem_next [CAPACITY];
    logic [PW-1:0]         mem_prev [CAPACITY];

    logic [PW-1:0] head_reg, tail_reg, cur_reg, free_reg;
    logic [PW-1:0] used_reg;
    logic [3:0]    func_reg;
    logic [DATA_WIDTH-1:0] din_reg;
    logic [PW-1:0] tgt_reg;
    logic [PW-1:0] clr_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [PW-1:0] rd_next_reg, rd_prev_reg, rd_fnext_reg;
    logic [PW-1:0] new_reg;
    logic [DATA_WIDTH-1:0] res_data_reg;
    logic [1:0]    res_st_reg;
    logic          fix2_reg;
    logic          done_reg;
    logic [DATA_WIDTH-1:0] nav_data_reg;
    logic          nav_ok_reg;

    logic [PW-1:0] tgt;
    logic          tgt_ok;
    logic          is_push;
    logic          is_nav;

    function automatic logic isn(input logic [PW-1:0] p);
        return p < NONE;
    endfunction

    always_comb
    begin
        tgt = cur_reg;
        unique case (func)
            FN_FIRST, FN_POP_FRONT: tgt = head_reg;
            FN_LAST, FN_POP_BACK, FN_PUSH_BACK: tgt = tail_reg;
            default: tgt = cur_reg;
        endcase
    end

    assign tgt_ok = isn(tgt_reg);
    assign is_push = (func_reg == FN_PUSH_FRONT) || (func_reg == FN_PUSH_BACK)
                     || (func_reg == FN_PUSH_AFTER);
    assign is_nav = (func_reg == FN_NEXT) || (func_reg == FN_PREV);
    assign stat.clr_last = (clr_reg == NONE - PW'(1));
    assign stat.need_fix2 = fix2_reg;
    assign data_out = res_data_reg;
    assign status = res_st_reg;
    assign done = done_reg;

    // memory access: clocked reads, one to three writes per step
    always_ff @(posedge clk)
    begin
        if (ctrl.read)
        begin
            rd_data_reg  <= mem_data[tgt_reg[IW-1:0]];
            rd_next_reg  <= mem_next[tgt_reg[IW-1:0]];
            rd_prev_reg  <= mem_prev[tgt_reg[IW-1:0]];
            rd_fnext_reg <= mem_next[free_reg[IW-1:0]];
        end
        if (ctrl.clr_step)
        begin
            mem_next[clr_reg[IW-1:0]] <= (clr_reg == NONE - PW'(1)) ? NONE
                                         : clr_reg + PW'(1);
            mem_prev[clr_reg[IW-1:0]] <= NONE;
        end
        if (ctrl.exec)
        begin
            unique case (func_reg)
                FN_PUSH_FRONT, FN_PUSH_BACK, FN_PUSH_AFTER:
                    if (isn(free_reg))
                    begin
                        mem_data[free_reg[IW-1:0]] <= din_reg;
                        if (func_reg == FN_PUSH_FRONT || !tgt_ok)
                        begin
                            mem_next[free_reg[IW-1:0]] <= head_reg;
                            mem_prev[free_reg[IW-1:0]] <= NONE;
                        end
                        else
                        begin
                            mem_next[free_reg[IW-1:0]] <= rd_next_reg;
                            mem_prev[free_reg[IW-1:0]] <= tgt_reg;
                        end
                    end
                FN_POP_FRONT, FN_POP_BACK, FN_POP_CURSOR:
                    if (tgt_ok)
                    begin
                        mem_next[tgt_reg[IW-1:0]] <= free_reg;
                        mem_prev[tgt_reg[IW-1:0]] <= NONE;
                    end
                default: ;
            endcase
        end
        if (ctrl.fix1)
        begin
            unique case (func_reg)
                FN_PUSH_FRONT, FN_PUSH_BACK, FN_PUSH_AFTER:
                    if (isn(new_reg))
                    begin
                        if (func_reg == FN_PUSH_FRONT || !tgt_ok)
                        begin
                            if (isn(head_reg))
                                mem_prev[head_reg[IW-1:0]] <= new_reg;
                        end
                        else
                        begin
                            mem_next[tgt_reg[IW-1:0]] <= new_reg;
                        end
                    end
                FN_POP_FRONT, FN_POP_BACK, FN_POP_CURSOR:
                    if (tgt_ok && isn(rd_next_reg))
                        mem_prev[rd_next_reg[IW-1:0]] <= rd_prev_reg;
                default: ;
            endcase
            nav_data_reg <= mem_data[tgt_reg[IW-1:0]];
        end
        if (ctrl.fix2)
        begin
            unique case (func_reg)
                FN_POP_FRONT, FN_POP_BACK, FN_POP_CURSOR:
                    if (isn(rd_prev_reg))
                        mem_next[rd_prev_reg[IW-1:0]] <= rd_next_reg;
                default:
                    if (isn(rd_next_reg))
                        mem_prev[rd_next_reg[IW-1:0]] <= new_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NONE;
            tail_reg <= NONE;
            cur_reg  <= NONE;
            free_reg <= '0;
            used_reg <= '0;
            clr_reg  <= '0;
            done_reg <= 1'b0;
            fix2_reg <= 1'b0;
            res_st_reg <= ST_OK;
            res_data_reg <= '0;
            func_reg <= '0;
            din_reg  <= '0;
            tgt_reg  <= NONE;
            new_reg  <= NONE;
        end
        else
        begin
            done_reg <= ctrl.finish;
            if (ctrl.load)
            begin
                func_reg <= func;
                din_reg  <= data_in;
                tgt_reg  <= tgt;
                res_data_reg <= '0;
                res_st_reg <= ctrl.clr_start ? ST_OK : ST_NULL;
                fix2_reg <= 1'b0;
                if (func == FN_PUSH_BACK)
                    cur_reg <= tail_reg;
                if (ctrl.clr_start)
                    clr_reg <= '0;
            end
            if (ctrl.clr_step)
            begin
                clr_reg <= clr_reg + PW'(1);
                if (stat.clr_last)
                begin
                    head_reg <= NONE;
                    tail_reg <= NONE;
                    cur_reg  <= NONE;
                    free_reg <= '0;
                    used_reg <= '0;
                end
            end
            if (ctrl.exec)
            begin
                new_reg <= (is_push && isn(free_reg)) ? free_reg : NONE;
                unique case (func_reg)
                    FN_FIRST, FN_LAST:
                        if (tgt_ok)
                        begin
                            cur_reg <= tgt_reg;
                            res_data_reg <= rd_data_reg;
                            res_st_reg <= ST_OK;
                        end
                    FN_NEXT, FN_PREV:
                        if (tgt_ok)
                        begin
                            tgt_reg <= (func_reg == FN_NEXT) ? rd_next_reg : rd_prev_reg;
                        end
                    FN_PUSH_FRONT, FN_PUSH_BACK, FN_PUSH_AFTER:
                        if (!isn(free_reg))
                        begin
                            res_st_reg <= ST_FULL;
                        end
                        else
                        begin
                            free_reg <= rd_fnext_reg;
                            used_reg <= used_reg + PW'(1);
                            res_st_reg <= ST_OK;
                            if (func_reg != FN_PUSH_FRONT && tgt_ok)
                            begin
                                if (!isn(rd_next_reg))
                                    tail_reg <= free_reg;
                                fix2_reg <= 1'b1;
                            end
                        end
                    FN_POP_FRONT, FN_POP_BACK, FN_POP_CURSOR:
                    begin
                        cur_reg <= NONE;
                        if (tgt_ok)
                        begin
                            res_data_reg <= rd_data_reg;
                            res_st_reg <= ST_OK;
                            free_reg <= tgt_reg;
                            if (used_reg != '0)
                                used_reg <= used_reg - PW'(1);
                            if (tgt_reg == head_reg)
                                head_reg <= rd_next_reg;
                            if (tgt_reg == tail_reg)
                                tail_reg <= rd_prev_reg;
                            fix2_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (ctrl.fix1 && is_nav)
            begin
                fix2_reg <= 1'b0;
            end
            // push at the front, or with no valid target, links in the new head as the old head is fixed
            if (ctrl.fix1 && is_push && isn(new_reg)
                && (func_reg == FN_PUSH_FRONT || !tgt_ok))
            begin
                head_reg <= new_reg;
                if (!isn(head_reg))
                    tail_reg <= new_reg;
            end
            if (ctrl.finish && is_nav && isn(tgt_reg) && nav_ok_reg)
            begin
                cur_reg <= tgt_reg;
                res_data_reg <= nav_data_reg;
                res_st_reg <= ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nav_ok_reg <= 1'b0;
        else if (ctrl.load)
            nav_ok_reg <= 1'b0;
        else if (ctrl.exec)
            nav_ok_reg <= tgt_ok;
    end

endmodule

@@ src/cursor_doubly_linked_list.sv @@
// cursor doubly linked list over a pool of nodes
// depends on cdll_pkg, cdll_ctrl, cdll_dp, cursor_doubly_linked_list_macros.svh
//
// one command transaction: start with func and data_in while busy is low;
// busy rises the next cycle. one result comes back on data_out and status
// with done high for exactly one cycle; the receiver cannot stall it.
// navigation, push and pop go from start to done through one memory read
// stage, one execute stage and one or two link fix stages. push back or
// after an existing node with room in the pool, and pop of an existing
// node, use two fix stages, the rest one. clear sweeps the pool one node
// per cycle. busy is low while done is high, so the next command may be
// accepted in the done cycle. after reset an init sweep chains every node
// on the free list while busy is high, and no result is produced; then the
// list is empty and the cursor is none.
// status 0 ok, 1 nothing there, 2 pool full with the push dropped.
module cursor_doubly_linked_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [3:0]            func,
    input  logic [DATA_WIDTH-1:0] data_in,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] data_out,
    output logic [1:0]            status
);
    import cdll_pkg::*;
    `include "cursor_doubly_linked_list_macros.svh"

    ctrl_t ctrl;
    stat_t stat;

    cdll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .is_clear (func == FN_CLEAR),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    cdll_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .func     (func),
        .data_in  (data_in),
        .stat     (stat),
        .data_out (data_out),
        .status   (status),
        .done     (done)
    );

    `CDLL_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `CDLL_ASSERT_IMPL(a_done_busy, clk, rst_n, ctrl.finish, busy)
    `CDLL_ASSERT_IMPL(a_status_range, clk, rst_n, done, status != 2'd3)
    `CDLL_ASSERT_IMPL(a_null_zero, clk, rst_n, done && status != ST_OK, data_out == '0)

endmodule

@@ tb/sv/cursor_doubly_linked_list_tb.sv @@
// self-checking testbench for the cursor doubly linked list
// depends on cdll_pkg and cursor_doubly_linked_list; models the list in a node pool
// and compares every done transaction against the predicted data and status
module cursor_doubly_linked_list_tb;
    import cdll_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 16;
    localparam logic [4:0] NIL = 5'(CAP);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [3:0] func = 4'd0;
    logic [31:0] data_in = 32'd0;
    logic busy, done;
    logic [31:0] data_out;
    logic [1:0] status;

    always #4 clk = ~clk;

    cursor_doubly_linked_list #(.CAPACITY(CAP), .DATA_WIDTH(32)) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .data_in(data_in), .done(done), .data_out(data_out), .status(status)
    );

    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  st;
    } list_result_t;

    list_result_t pending_results[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int full_seen = 0;
    int null_seen = 0;

    logic [31:0] m_data [CAP];
    logic [4:0]  m_next [CAP];
    logic [4:0]  m_prev [CAP];
    logic [4:0]  m_head, m_tail, m_cur, m_free;
    int          m_used;

    function automatic bit valid_node(logic [4:0] p);
        return p < 5'(CAP);
    endfunction

    function automatic void list_reset();
        for (int i = 0; i < CAP; i++)
        begin
            m_next[i] = (i + 1 < CAP) ? 5'(i + 1) : NIL;
            m_prev[i] = NIL;
        end
        m_head = NIL;
        m_tail = NIL;
        m_cur = NIL;
        m_free = 5'd0;
        m_used = 0;
    endfunction

    function automatic logic [4:0] take_node(logic [31:0] v);
        logic [4:0] n;
        n = m_free;
        if (!valid_node(n))
            return NIL;
        m_free = m_next[n];
        m_data[n] = v;
        m_next[n] = NIL;
        m_prev[n] = NIL;
        m_used++;
        return n;
    endfunction

    function automatic logic [1:0] insert_front(logic [31:0] v);
        logic [4:0] n;
        n = take_node(v);
        if (!valid_node(n))
            return ST_FULL;
        if (!valid_node(m_head))
        begin
            m_head = n;
            m_tail = n;
        end
        else
        begin
            m_next[n] = m_head;
            m_prev[m_head] = n;
            m_head = n;
        end
        return ST_OK;
    endfunction

    function automatic logic [1:0] insert_after(logic [31:0] v);
        logic [4:0] c, n;
        c = m_cur;
        if (!valid_node(c))
            return insert_front(v);
        n = take_node(v);
        if (!valid_node(n))
            return ST_FULL;
        m_next[n] = m_next[c];
        m_prev[n] = c;
        if (valid_node(m_next[c]))
            m_prev[m_next[c]] = n;
        else
            m_tail = n;
        m_next[c] = n;
        return ST_OK;
    endfunction

    function automatic logic [1:0] remove_cursor(output logic [31:0] v);
        logic [4:0] t, nx, pv;
        t = m_cur;
        m_cur = NIL;
        v = 32'd0;
        if (!valid_node(t))
            return ST_NULL;
        v = m_data[t];
        nx = m_next[t];
        pv = m_prev[t];
        if (t == m_head)
        begin
            m_head = nx;
            if (valid_node(nx))
                m_prev[nx] = NIL;
        end
        else if (valid_node(pv))
            m_next[pv] = nx;
        if (t == m_tail)
        begin
            m_tail = pv;
            if (valid_node(pv))
                m_next[pv] = NIL;
        end
        else if (valid_node(nx))
            m_prev[nx] = pv;
        m_prev[t] = NIL;
        m_next[t] = m_free;
        m_free = t;
        if (m_used > 0)
            m_used--;
        return ST_OK;
    endfunction

    function automatic logic [1:0] go_to(logic [4:0] target, output logic [31:0] v);
        v = 32'd0;
        if (!valid_node(target))
            return ST_NULL;
        m_cur = target;
        v = m_data[target];
        return ST_OK;
    endfunction

    function automatic list_result_t predict_list_op(logic [3:0] f, logic [31:0] d);
        list_result_t r;
        logic [31:0] v;
        v = 32'd0;
        r.st = ST_NULL;
        case (f)
            FN_FIRST:      r.st = go_to(m_head, v);
            FN_NEXT:       if (valid_node(m_cur)) r.st = go_to(m_next[m_cur], v);
            FN_LAST:       r.st = go_to(m_tail, v);
            FN_PREV:       if (valid_node(m_cur)) r.st = go_to(m_prev[m_cur], v);
            FN_PUSH_FRONT: r.st = insert_front(d);
            FN_PUSH_BACK:
            begin
                m_cur = m_tail;
                r.st = insert_after(d);
            end
            FN_PUSH_AFTER: r.st = insert_after(d);
            FN_POP_FRONT:
            begin
                m_cur = m_head;
                r.st = remove_cursor(v);
            end
            FN_POP_BACK:
            begin
                m_cur = m_tail;
                r.st = remove_cursor(v);
            end
            FN_POP_CURSOR: r.st = remove_cursor(v);
            FN_CLEAR:
            begin
                list_reset();
                r.st = ST_OK;
            end
            default: ;
        endcase
        r.data = (r.st == ST_OK) ? v : 32'd0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, checked);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", data_out, 32'd0);
            else
            begin
                list_result_t w;
                w = pending_results.pop_front();
                if (data_out !== w.data)
                    report_mismatch("data_out", data_out, w.data);
                if (status !== w.st)
                    report_mismatch("status", {30'd0, status}, {30'd0, w.st});
                if (w.st == ST_FULL) full_seen++;
                if (w.st == ST_NULL) null_seen++;
            end
            checked++;
        end
    end

    int burst_left = 0;

    // one command transaction; start is raised once busy is low and dropped after each item
    task automatic send_op(logic [3:0] f, logic [31:0] d);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        burst_left--;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        start <= 1'b1;
        func <= f;
        data_in <= d;
        pending_results.push_back(predict_list_op(f, d));
        sent++;
        @(posedge clk);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic test_empty_list();
        for (int f = 0; f < 16; f++)
            send_op(4'(f), $urandom());
    endtask

    task automatic test_fill_and_full();
        send_op(FN_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(FN_PUSH_BACK, 32'h0000_0000);
        send_op(FN_PUSH_AFTER, 32'hA5A5_5A5A);
        for (int i = 0; i < CAP; i++)
            send_op(FN_PUSH_BACK, $urandom());
        send_op(FN_PUSH_FRONT, 32'h1234_5678);
        send_op(FN_PUSH_AFTER, 32'h8765_4321);
        send_op(FN_LAST, 32'd0);
        send_op(FN_NEXT, 32'd0);
        send_op(FN_FIRST, 32'd0);
        send_op(FN_PREV, 32'd0);
        send_op(FN_POP_CURSOR, 32'd0);
        send_op(FN_POP_CURSOR, 32'd0);
        send_op(FN_CLEAR, 32'd0);
        wait_drained();
    endtask

    task automatic test_random_ops(int count);
        logic [3:0] f;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 1)
                f = FN_CLEAR;
            else if (r < 3)
                f = 4'($urandom_range(11, 15));
            else if (r < 40)
                f = 4'($urandom_range(FN_PUSH_FRONT, FN_PUSH_AFTER));
            else if (r < 70)
                f = 4'($urandom_range(FN_FIRST, FN_PREV));
            else
                f = 4'($urandom_range(FN_POP_FRONT, FN_POP_CURSOR));
            send_op(f, $urandom());
        end
        wait_drained();
    endtask

    initial
    begin
        list_reset();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_fill_and_full();
        test_random_ops(750);
        test_random_ops(780);
        repeat (30) @(negedge clk);
        $display("ran %0d list operations, %0d results checked", sent, checked);
        $display("saw %0d nothing-there and %0d pool-full results", null_seen, full_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("cursor_doubly_linked_list_tb: PASS");
        else
            $display("cursor_doubly_linked_list_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("cursor_doubly_linked_list_tb: FAIL");
        $finish;
    end
endmodule
